// ===== design/resub_feasibility_check_assert.svh =====
// ----------------------------------------------------------------------------
// Resubstitution feasibility check assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RESUB_FEASIBILITY_CHECK_ASSERT_SVH
`define RESUB_FEASIBILITY_CHECK_ASSERT_SVH

// Same-cycle implication.
`define RFC_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define RFC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Resubstitution feasibility check package
// Sizes and shared types of the lane decoders, merge stage and seen tracker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int WORD_BITS   = 32;
    localparam int MAX_NODES   = 7;
    localparam int INPUT_BITS  = 32;
    localparam int NODE_SLOTS  = 7;
    localparam int COUNT_BITS  = 3;
    localparam int PAT_BITS    = 7;
    localparam int PATTERNS    = 128;

    typedef logic [INPUT_BITS-1:0] word_t;

    typedef struct packed {
        logic                root;
        logic [PAT_BITS-1:0] pattern;
    } rfc_lane_t;

    typedef struct packed {
        logic [PATTERNS-1:0] hit_zero;
        logic [PATTERNS-1:0] hit_one;
        logic                last;
    } rfc_marks_t;

endpackage

// ===== design/rfc_lane.sv =====
// ----------------------------------------------------------------------------
// Lane decoder
// Forms the pattern index of one bit lane from the enabled node bits.
// ----------------------------------------------------------------------------
module rfc_lane (
    input  logic                           root_bit,
    input  logic [rfc_pkg::NODE_SLOTS-1:0] node_bits,
    input  logic [rfc_pkg::COUNT_BITS-1:0] node_count,
    output rfc_pkg::rfc_lane_t             lane_out
);

    always_comb begin
        lane_out.root    = root_bit;
        lane_out.pattern = '0;
        for (int k = 0; k < rfc_pkg::NODE_SLOTS; k++) begin
            lane_out.pattern[k] = node_bits[k] &&
                                  (rfc_pkg::COUNT_BITS'(k) < node_count);
        end
    end

endmodule

// ===== design/rfc_merge.sv =====
// ----------------------------------------------------------------------------
// Lane merge stage
// ORs the one-hot pattern marks of all lanes into two registered hit masks.
// ----------------------------------------------------------------------------
module rfc_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rfc_pkg::rfc_lane_t   lanes [rfc_pkg::WORD_BITS],
    input  logic                 last_word,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 marks_valid,
    input  logic                 marks_ready,
    output rfc_pkg::rfc_marks_t  marks
);

    logic                in_accept;
    logic                valid_reg;
    logic                valid_next;
    rfc_pkg::rfc_marks_t marks_reg;
    rfc_pkg::rfc_marks_t marks_next;

    assign in_ready    = !valid_reg || marks_ready;
    assign in_accept   = in_valid && in_ready;
    assign marks_valid = valid_reg;
    assign marks       = marks_reg;

    always_comb begin
        marks_next      = marks_reg;
        valid_next      = valid_reg;
        if (in_accept) begin
            marks_next.hit_zero = '0;
            marks_next.hit_one  = '0;
            marks_next.last     = last_word;
            for (int i = 0; i < rfc_pkg::WORD_BITS; i++) begin
                if (lanes[i].root) begin
                    marks_next.hit_one[lanes[i].pattern] = 1'b1;
                end else begin
                    marks_next.hit_zero[lanes[i].pattern] = 1'b1;
                end
            end
            valid_next = 1'b1;
        end else if (marks_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        marks_reg <= marks_next;
    end

    `include "resub_feasibility_check_assert.svh"

    `RFC_ASSERT_NEXT(a_accept_fills, in_accept, valid_reg)
    `RFC_ASSERT_NEXT(a_stall_holds, valid_reg && !marks_ready, valid_reg && $stable(marks_reg))
    `RFC_ASSERT_IMPLY(a_marks_nonempty, valid_reg, (|marks_reg.hit_zero) || (|marks_reg.hit_one))

endmodule

// ===== design/rfc_seen_track.sv =====
// ----------------------------------------------------------------------------
// Seen-set tracker
// Accumulates the hit masks of a query, checks for conflicts and holds the
// registered result until the downstream transfer.
// ----------------------------------------------------------------------------
module rfc_seen_track (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                marks_valid,
    output logic                marks_ready,
    input  rfc_pkg::rfc_marks_t marks,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_still_feasible,
    output logic                m_verdict_final
);

    logic                         take;
    logic [rfc_pkg::PATTERNS-1:0] seen0_reg;
    logic [rfc_pkg::PATTERNS-1:0] seen1_reg;
    logic [rfc_pkg::PATTERNS-1:0] seen0_next;
    logic [rfc_pkg::PATTERNS-1:0] seen1_next;
    logic [rfc_pkg::PATTERNS-1:0] merged0;
    logic [rfc_pkg::PATTERNS-1:0] merged1;
    logic                         valid_reg;
    logic                         feasible_reg;
    logic                         final_reg;

    assign marks_ready = !valid_reg || m_ready;
    assign take        = marks_valid && marks_ready;
    assign merged0     = seen0_reg | marks.hit_zero;
    assign merged1     = seen1_reg | marks.hit_one;

    always_comb begin
        seen0_next = seen0_reg;
        seen1_next = seen1_reg;
        if (take) begin
            seen0_next = marks.last ? '0 : merged0;
            seen1_next = marks.last ? '0 : merged1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            seen0_reg <= '0;
            seen1_reg <= '0;
        end else begin
            seen0_reg <= seen0_next;
            seen1_reg <= seen1_next;
            if (take) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
        if (take) begin
            feasible_reg <= ~|(merged0 & merged1);
            final_reg    <= marks.last;
        end
    end

    assign m_valid          = valid_reg;
    assign m_still_feasible = feasible_reg;
    assign m_verdict_final  = final_reg;

    `include "resub_feasibility_check_assert.svh"

    `RFC_ASSERT_NEXT(a_clear_after_last, take && marks.last, seen0_reg == '0 && seen1_reg == '0)
    `RFC_ASSERT_NEXT(a_take_loads_result, take, valid_reg)
    `RFC_ASSERT_IMPLY(a_feasible_matches_sets, valid_reg && feasible_reg && !final_reg, ~|(seen0_reg & seen1_reg))

endmodule

// ===== design/resub_feasibility_check.sv =====
// ----------------------------------------------------------------------------
// Resubstitution feasibility check
// Streams simulation words of a query and reports whether the candidate
// nodes can still implement the root.
// ----------------------------------------------------------------------------
// The block takes one simulation word in every clock cycle while the result
// side keeps up, and returns one result per word: one register stage holds
// the merged pattern marks of all bit lanes, and the output register
// holds the result while the seen sets are updated. The 32 lane decoders
// work in parallel and their marks are merged by a wide OR, so the sustained
// rate is one transfer per cycle whenever the result side keeps up.
// ----------------------------------------------------------------------------
module resub_feasibility_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_root_word,
    input  logic [31:0] s_node0_word,
    input  logic [31:0] s_node1_word,
    input  logic [31:0] s_node2_word,
    input  logic [31:0] s_node3_word,
    input  logic [31:0] s_node4_word,
    input  logic [31:0] s_node5_word,
    input  logic [31:0] s_node6_word,
    input  logic [2:0]  s_node_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_still_feasible,
    output logic        m_verdict_final
);

    rfc_pkg::word_t                  node_words [rfc_pkg::NODE_SLOTS];
    logic [rfc_pkg::COUNT_BITS-1:0]  count_eff;
    rfc_pkg::rfc_lane_t              lanes [rfc_pkg::WORD_BITS];
    logic                            marks_valid;
    logic                            marks_ready;
    rfc_pkg::rfc_marks_t             marks;

    assign node_words[0] = s_node0_word;
    assign node_words[1] = s_node1_word;
    assign node_words[2] = s_node2_word;
    assign node_words[3] = s_node3_word;
    assign node_words[4] = s_node4_word;
    assign node_words[5] = s_node5_word;
    assign node_words[6] = s_node6_word;

    assign count_eff = (s_node_count > rfc_pkg::COUNT_BITS'(rfc_pkg::MAX_NODES)) ?
                       rfc_pkg::COUNT_BITS'(rfc_pkg::MAX_NODES) : s_node_count;

    for (genvar i = 0; i < rfc_pkg::WORD_BITS; i++) begin : g_lane
        logic                           lane_root;
        logic [rfc_pkg::NODE_SLOTS-1:0] lane_nodes;

        if (i < rfc_pkg::INPUT_BITS) begin : g_live
            assign lane_root = s_root_word[i];
            for (genvar k = 0; k < rfc_pkg::NODE_SLOTS; k++) begin : g_node
                assign lane_nodes[k] = node_words[k][i];
            end
        end else begin : g_pad
            assign lane_root  = 1'b0;
            assign lane_nodes = '0;
        end

        rfc_lane u_lane (
            .root_bit   (lane_root),
            .node_bits  (lane_nodes),
            .node_count (count_eff),
            .lane_out   (lanes[i])
        );
    end

    rfc_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lanes       (lanes),
        .last_word   (s_last_word),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .marks_valid (marks_valid),
        .marks_ready (marks_ready),
        .marks       (marks)
    );

    rfc_seen_track u_track (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .marks_valid      (marks_valid),
        .marks_ready      (marks_ready),
        .marks            (marks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_still_feasible (m_still_feasible),
        .m_verdict_final  (m_verdict_final)
    );

endmodule
